FILE: hdl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants of the line pixel rasterizer
// Holds the sequencer states, draw modes, item kinds, register map and the
// fixed field widths used by the rasterizer and its divider.
// ----------------------------------------------------------------------------
package lpr_pkg;

   // Fixed field widths.
   localparam int ORIGIN_BITS   = 12;
   localparam int COLOR_BITS    = 24;
   localparam int PIXEL_BITS    = 14;
   localparam int RSP_DATA_BITS = 56;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Reset values of the configuration registers.
   localparam logic [ORIGIN_BITS-1:0] ORIGIN_X_RESET = 12'd10;
   localparam logic [ORIGIN_BITS-1:0] ORIGIN_Y_RESET = 12'd480;

   // Register indexes; a register sits at byte address 4 * index.
   localparam logic REG_ORIGIN_X = 1'b0;
   localparam logic REG_ORIGIN_Y = 1'b1;

   // Item kinds carried on tuser.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_STEP = 1'b1;

   typedef enum logic [1:0] {
      MODE_POINT = 2'd0,
      MODE_HORIZ = 2'd1,
      MODE_VERT  = 2'd2,
      MODE_SLANT = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_SUM,
      ST_DIV_GO,
      ST_DIV,
      ST_EMIT
   } state_type;

   // Status of the shared divider as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

FILE: hdl/lpr_divider.sv
// ----------------------------------------------------------------------------
// lpr_divider: iterative signed divider, one quotient bit per cycle
// Divides magnitudes by restoring subtraction against a shifted divisor and
// applies the sign at the end, so the quotient truncates toward zero. The
// caller guarantees that the quotient magnitude fits in QUO_BITS bits.
// ----------------------------------------------------------------------------
module lpr_divider #(
   parameter int NUM_BITS = 29,
   parameter int DEN_BITS = 14,
   parameter int QUO_BITS = 13
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [NUM_BITS-1:0]    num,
   input  logic signed [DEN_BITS-1:0]    den,
   output lpr_pkg::div_status_type       status,
   output logic signed [QUO_BITS:0]      quo
);
   import lpr_pkg::*;

   localparam int SH_BITS  = DEN_BITS + QUO_BITS;
   localparam int CMP_BITS = (NUM_BITS > SH_BITS) ? NUM_BITS : SH_BITS;
   localparam int CNT_BITS = $clog2(QUO_BITS + 1);

   logic [CMP_BITS-1:0] rem_ff, rem_in;
   logic [CMP_BITS-1:0] dsh_ff, dsh_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;

   logic [NUM_BITS-1:0] num_abs;
   logic [DEN_BITS-1:0] den_abs;
   logic [QUO_BITS:0]   quo_mag;

   assign num_abs = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
   assign den_abs = den[DEN_BITS-1] ? DEN_BITS'(-den) : DEN_BITS'(den);

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      if (start) begin
         rem_in  = CMP_BITS'(num_abs);
         dsh_in  = CMP_BITS'(den_abs) << (QUO_BITS - 1);
         quo_in  = '0;
         cnt_in  = CNT_BITS'(QUO_BITS);
         busy_in = 1'b1;
         neg_in  = num[NUM_BITS-1] ^ den[DEN_BITS-1];
      end else if (busy_ff) begin
         if (rem_ff >= dsh_ff) begin
            rem_in = rem_ff - dsh_ff;
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUO_BITS-2:0], 1'b0};
         end
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign quo_mag     = {1'b0, quo_ff};
   assign quo         = neg_ff ? (~quo_mag + 1'b1) : quo_mag;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

FILE: hdl/line_pixel_rasterizer.sv
// ----------------------------------------------------------------------------
// line_pixel_rasterizer: naive slope line rasterizer, one pixel per step item
// Loads two endpoints and a color, moves them into screen space and emits
// one pixel per step item while a line is pending, with a last flag on the final pixel.
// ----------------------------------------------------------------------------
// A load item is taken without leaving idle and gives no result. A step on a
// point, horizontal or vertical line goes through the emit state, which waits
// while the output register is full, and its pixel is offered as the sequencer
// returns to idle and can take the next item. A step on a slanted line runs the
// shared multiplier twice and the shared divider over CW - 1 quotient bits
// (CW = max(COORD_BITS, 12) + 2) before it is emitted. Reset is synchronous and
// clears the sequencer, the pending line and the output, and returns the origins to 10 and 480.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer #(
   parameter int COORD_BITS = 12
) (
   input  logic clock,
   input  logic reset,

   // Input items.
   input  logic req_tvalid,
   output logic req_tready,
   // tdata, low to high: start_x, start_y, end_x, end_y, color_rgb, zero pad.
   input  logic [((4*COORD_BITS + lpr_pkg::COLOR_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: kind (0 loads a line, 1 asks for the next pixel).
   input  logic req_tuser,

   // Result items.
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata, low to high: pixel_x, pixel_y, pixel_color, zero pad.
   output logic [lpr_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic rsp_tlast,

   // Configuration registers.
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lpr_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [lpr_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [lpr_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import lpr_pkg::*;

   // Internal coordinate width: holds every screen coordinate and span.
   localparam int CW = ((COORD_BITS > ORIGIN_BITS) ? COORD_BITS : ORIGIN_BITS) + 2;
   // Width of the slope numerator y1*dx + dy*(x - x1).
   localparam int NW = 2 * CW + 1;
   localparam int PAD_BITS = RSP_DATA_BITS - 2 * PIXEL_BITS - COLOR_BITS;

   // ---------------------------------------------------------------------
   // Field unpacking
   // ---------------------------------------------------------------------
   logic signed [COORD_BITS-1:0] in_start_x, in_start_y, in_end_x, in_end_y;
   logic [COLOR_BITS-1:0]        in_color;

   assign in_start_x = req_tdata[0*COORD_BITS +: COORD_BITS];
   assign in_start_y = req_tdata[1*COORD_BITS +: COORD_BITS];
   assign in_end_x   = req_tdata[2*COORD_BITS +: COORD_BITS];
   assign in_end_y   = req_tdata[3*COORD_BITS +: COORD_BITS];
   assign in_color   = req_tdata[4*COORD_BITS +: COLOR_BITS];

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   logic [ORIGIN_BITS-1:0] origin_x_ff, origin_x_in;
   logic [ORIGIN_BITS-1:0] origin_y_ff, origin_y_in;

   state_type state_ff, state_in;

   logic                 line_active_ff, line_active_in;
   mode_type             draw_mode_ff, draw_mode_in;
   logic signed [CW-1:0] walk_pos_ff, walk_pos_in;
   logic signed [CW-1:0] walk_end_ff, walk_end_in;
   logic signed [CW-1:0] anchor_x_ff, anchor_x_in;
   logic signed [CW-1:0] anchor_y_ff, anchor_y_in;
   logic signed [CW-1:0] delta_x_ff, delta_x_in;
   logic signed [CW-1:0] delta_y_ff, delta_y_in;
   logic [COLOR_BITS-1:0] line_color_ff, line_color_in;

   logic signed [2*CW-1:0] prod_ff, prod_in;
   logic signed [NW-1:0]   acc_ff, acc_in;

   logic [PIXEL_BITS-1:0] res_x_ff, res_x_in;
   logic [PIXEL_BITS-1:0] res_y_ff, res_y_in;
   logic                  res_last_ff, res_last_in;

   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_last_ff, rsp_last_in;

   // ---------------------------------------------------------------------
   // Load path: move endpoints into screen space. Screen y is flipped so
   // that y grows downward from the origin_y line.
   // ---------------------------------------------------------------------
   localparam logic signed [CW-1:0] CoordOne = CW'(1);

   logic signed [CW-1:0] ld_x1, ld_y1, ld_x2, ld_y2, ld_dx, ld_dy;
   logic signed [CW-1:0] ld_xmin, ld_xmax, ld_ymin, ld_ymax;

   assign ld_x1 = CW'(in_start_x) + $signed(CW'(origin_x_ff));
   assign ld_x2 = CW'(in_end_x) + $signed(CW'(origin_x_ff));
   assign ld_y1 = $signed(CW'(origin_y_ff)) - CW'(in_start_y) + CoordOne;
   assign ld_y2 = $signed(CW'(origin_y_ff)) - CW'(in_end_y) + CoordOne;
   assign ld_dx = ld_x2 - ld_x1;
   assign ld_dy = ld_y2 - ld_y1;
   assign ld_xmin = (ld_x1 < ld_x2) ? ld_x1 : ld_x2;
   assign ld_xmax = (ld_x1 < ld_x2) ? ld_x2 : ld_x1;
   assign ld_ymin = (ld_y1 < ld_y2) ? ld_y1 : ld_y2;
   assign ld_ymax = (ld_y1 < ld_y2) ? ld_y2 : ld_y1;

   // ---------------------------------------------------------------------
   // Shared multiplier. The sequencer feeds it y1*dx first and then
   // dy*(x - x1); its product is always registered before use.
   // ---------------------------------------------------------------------
   logic signed [CW-1:0] mul_a, mul_b, walk_off;

   assign walk_off = walk_pos_ff - anchor_x_ff;

   always_comb begin
      mul_a = anchor_y_ff;
      mul_b = delta_x_ff;
      if (state_ff == ST_MUL_B) begin
         mul_a = delta_y_ff;
         mul_b = walk_off;
      end
   end

   assign prod_in = mul_a * mul_b;

   // ---------------------------------------------------------------------
   // Shared divider: numerator / dx, truncated toward zero. The screen y of
   // a slanted line lies between its endpoints, so CW - 1 quotient bits do.
   // ---------------------------------------------------------------------
   div_status_type       div_status;
   logic signed [CW-1:0] div_quo;
   logic                 div_start;

   assign div_start = (state_ff == ST_DIV_GO);

   lpr_divider #(
      .NUM_BITS (NW),
      .DEN_BITS (CW),
      .QUO_BITS (CW - 1)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (acc_ff),
      .den    (delta_x_ff),
      .status (div_status),
      .quo    (div_quo)
   );

   // ---------------------------------------------------------------------
   // Configuration port. Only address bit 2 selects the register; the low
   // two bits pick a byte within the word and are ignored.
   // ---------------------------------------------------------------------
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[2])
         REG_ORIGIN_X: csr_prdata = CSR_DATA_BITS'(origin_x_ff);
         REG_ORIGIN_Y: csr_prdata = CSR_DATA_BITS'(origin_y_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   logic req_fire;
   logic walk_last;
   logic emit_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   // A point is always its own last pixel; a run ends at its far end.
   assign walk_last  = (draw_mode_ff == MODE_POINT) || (walk_pos_ff >= walk_end_ff);
   // The output register takes a new item when empty or being drained.
   assign emit_fire  = (state_ff == ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      origin_x_in    = origin_x_ff;
      origin_y_in    = origin_y_ff;
      state_in       = state_ff;
      line_active_in = line_active_ff;
      draw_mode_in   = draw_mode_ff;
      walk_pos_in    = walk_pos_ff;
      walk_end_in    = walk_end_ff;
      anchor_x_in    = anchor_x_ff;
      anchor_y_in    = anchor_y_ff;
      delta_x_in     = delta_x_ff;
      delta_y_in     = delta_y_ff;
      line_color_in  = line_color_ff;
      acc_in         = acc_ff;
      res_x_in       = res_x_ff;
      res_y_in       = res_y_ff;
      res_last_in    = res_last_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_write) begin
         case (csr_paddr[2])
            REG_ORIGIN_X: origin_x_in = csr_pwdata[ORIGIN_BITS-1:0];
            REG_ORIGIN_Y: origin_y_in = csr_pwdata[ORIGIN_BITS-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == KIND_LOAD)) begin
               // A load replaces any line still pending.
               line_active_in = 1'b1;
               anchor_x_in    = ld_x1;
               anchor_y_in    = ld_y1;
               delta_x_in     = ld_dx;
               delta_y_in     = ld_dy;
               line_color_in  = in_color;
               if ((ld_dx != '0) && (ld_dy != '0)) begin
                  draw_mode_in = MODE_SLANT;
                  walk_pos_in  = ld_xmin;
                  walk_end_in  = ld_xmax;
               end else if (ld_dx != '0) begin
                  draw_mode_in = MODE_HORIZ;
                  walk_pos_in  = ld_xmin;
                  walk_end_in  = ld_xmax;
               end else if (ld_dy != '0) begin
                  draw_mode_in = MODE_VERT;
                  walk_pos_in  = ld_ymin;
                  walk_end_in  = ld_ymax;
               end else begin
                  draw_mode_in = MODE_POINT;
                  walk_pos_in  = '0;
                  walk_end_in  = '0;
               end
            end else if (req_fire && line_active_ff) begin
               // A step with no line pending falls through and gives nothing.
               res_last_in = walk_last;
               case (draw_mode_ff)
                  MODE_HORIZ: begin
                     res_x_in = walk_pos_ff[PIXEL_BITS-1:0];
                     res_y_in = anchor_y_ff[PIXEL_BITS-1:0];
                     state_in = ST_EMIT;
                  end
                  MODE_VERT: begin
                     res_x_in = anchor_x_ff[PIXEL_BITS-1:0];
                     res_y_in = walk_pos_ff[PIXEL_BITS-1:0];
                     state_in = ST_EMIT;
                  end
                  MODE_SLANT: begin
                     res_x_in = walk_pos_ff[PIXEL_BITS-1:0];
                     state_in = ST_MUL_A;
                  end
                  default: begin
                     res_x_in = anchor_x_ff[PIXEL_BITS-1:0];
                     res_y_in = anchor_y_ff[PIXEL_BITS-1:0];
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_MUL_A: begin
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            acc_in   = NW'(prod_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            acc_in   = acc_ff + NW'(prod_ff);
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               res_y_in = div_quo[PIXEL_BITS-1:0];
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_fire) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {PAD_BITS'(0), line_color_ff, res_y_ff, res_x_ff};
               rsp_last_in   = res_last_ff;
               if (res_last_ff) begin
                  line_active_in = 1'b0;
               end else begin
                  walk_pos_in = walk_pos_ff + CoordOne;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         line_active_ff <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
         origin_x_ff    <= ORIGIN_X_RESET;
         origin_y_ff    <= ORIGIN_Y_RESET;
      end else begin
         state_ff       <= state_in;
         line_active_ff <= line_active_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
         origin_x_ff    <= origin_x_in;
         origin_y_ff    <= origin_y_in;
      end
      draw_mode_ff  <= draw_mode_in;
      walk_pos_ff   <= walk_pos_in;
      walk_end_ff   <= walk_end_in;
      anchor_x_ff   <= anchor_x_in;
      anchor_y_ff   <= anchor_y_in;
      delta_x_ff    <= delta_x_in;
      delta_y_ff    <= delta_y_in;
      line_color_ff <= line_color_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_last_ff   <= res_last_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------

   // The divider is only started when it is free.
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   // The divider only finishes while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the wait state");

   // A new result only appears from the emit state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised outside the emit state");

   // Handing out the last pixel ends the line.
   assert property (@(posedge clock) disable iff (reset)
      (emit_fire && res_last_ff) |=> !line_active_ff)
      else $error("line still pending after its last pixel");

endmodule
